/* src/pcm_float_sample_converter_unit_defines.svh */
// Assertion macros for the PCM/float sample converter.
// Included by modules that carry concurrent assertions; no dependencies.
`ifndef PCM_FLOAT_SAMPLE_CONVERTER_UNIT_DEFINES_SVH
`define PCM_FLOAT_SAMPLE_CONVERTER_UNIT_DEFINES_SVH

// Implication checked at every rising clock edge outside reset.
`define PFSC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that holds at every rising clock edge, reset included.
`define PFSC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/pfsc_pkg.sv */
// Package for the PCM/float sample converter: format and kind codes,
// scale constants and the leading-zero count. No dependencies.
package pfsc_pkg;

    typedef enum logic [1:0] {
        FMT_S16 = 2'd0,
        FMT_S24 = 2'd1,
        FMT_S32 = 2'd2,
        FMT_RSV = 2'd3
    } t_fmt;

    typedef enum logic {
        KIND_PCM2FLT = 1'b0,
        KIND_FLT2PCM = 1'b1
    } t_kind;

    localparam int unsigned PW = 56;

    localparam logic [31:0] SCALE_S16 = 32'd32767;
    localparam logic [31:0] SCALE_S24 = 32'd8388607;
    localparam logic [31:0] SCALE_S32 = 32'h8000_0000;
    localparam logic [31:0] MAX_S16   = 32'h0000_7FFF;
    localparam logic [31:0] MAX_S24   = 32'h007F_FFFF;
    localparam logic [31:0] MAX_S32   = 32'h7FFF_FFFF;
    localparam logic [31:0] MASK_S16  = 32'h0000_FFFF;
    localparam logic [31:0] MASK_S24  = 32'h00FF_FFFF;
    localparam logic [31:0] MASK_S32  = 32'hFFFF_FFFF;
    localparam logic [23:0] HIDDEN    = 24'h80_0000;

    function automatic logic [5:0] lzc56(input logic [PW-1:0] v);
        logic [5:0] n;
        logic       found;
        n     = 6'd56;
        found = 1'b0;
        for (int i = PW - 1; i >= 0; i--) begin
            if (!found && v[i]) begin
                n     = 6'(PW - 1 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

endpackage

/* src/pcm_float_sample_converter_unit.sv */
// Top level of the PCM/float sample converter, a four-stage pipeline.
// Depends on pfsc_pkg and pcm_float_sample_converter_unit_defines.svh.
//
// Channel   Direction  Content
// s_axis    in         tdata sample_in, tuser kind, tlast end_of_block
// m_axis    out        tdata sample_out, tlast block_last
// i_cfg_*   in         sample_format, written with i_cfg_wr_en
//
// One beat enters per cycle unless stalled; results pass registers r1 to r4.
// Stages are multiply, normalize, round to 24 bits, then pack or shift and saturate.
// The whole pipeline advances unless the output register holds a beat that is not taken.
// Synchronous active-low reset clears the valid bits and the format register.
`include "pcm_float_sample_converter_unit_defines.svh"

module pcm_float_sample_converter_unit
    import pfsc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] sample_in
    input  logic        s_axis_tuser,   // [0] kind
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] sample_out
    output logic        m_axis_tlast
);

    logic        r_fmt_valid;
    t_fmt        r_fmt;
    logic        adv;

    logic        r1_v, r1_kind, r1_last, r1_neg, r1_force;
    t_fmt        r1_fmt;
    logic [PW-1:0] r1_val;
    logic signed [9:0] r1_exp;

    logic        r2_v, r2_kind, r2_last, r2_neg, r2_force;
    t_fmt        r2_fmt;
    logic [PW-1:0] r2_norm;
    logic signed [9:0] r2_exp;

    logic        r3_v, r3_kind, r3_last, r3_neg, r3_force;
    t_fmt        r3_fmt;
    logic [24:0] r3_p;
    logic signed [9:0] r3_exp;

    logic        r4_v, r4_kind, r4_last;
    t_fmt        r4_fmt;
    logic [31:0] r4_data;

    t_fmt        n1_fmt;
    logic        n1_neg, n1_force;
    logic [PW-1:0] n1_val;
    logic signed [9:0] n1_exp;
    logic [31:0] mag, scale, maxpos, mask;
    logic [7:0]  fe;
    logic [22:0] ff;
    logic [23:0] fm;

    logic [5:0]  lz;
    logic        rnd;

    logic [31:0] n4_data;
    logic [7:0]  bexp;
    logic [33:0] r_int;
    logic [49:0] wide;
    logic [24:0] q;
    logic [4:0]  rsh;

    assign adv           = !(r4_v && !m_axis_tready);
    assign s_axis_tready = adv;
    assign m_axis_tvalid = r4_v;
    assign m_axis_tdata  = r4_data;
    assign m_axis_tlast  = r4_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt_valid <= 1'b0;
            r_fmt       <= FMT_S16;
        end else if (i_cfg_wr_en) begin
            r_fmt_valid <= 1'b1;
            r_fmt       <= t_fmt'(i_cfg_wr_data);
        end
    end

    // Stage 1: sign and magnitude, or clamp decode and scale multiply.
    always_comb begin
        n1_fmt   = (r_fmt == FMT_RSV) ? FMT_S32 : r_fmt;
        fe       = s_axis_tdata[30:23];
        ff       = s_axis_tdata[22:0];
        fm       = (fe == 8'd0) ? {1'b0, ff} : (HIDDEN | {1'b0, ff});
        n1_force = 1'b0;
        mag      = '0;
        unique case (n1_fmt)
            FMT_S16: scale = SCALE_S16;
            FMT_S24: scale = SCALE_S24;
            default: scale = SCALE_S32;
        endcase
        if (s_axis_tuser == KIND_PCM2FLT) begin
            unique case (n1_fmt)
                FMT_S16: begin
                    n1_neg = s_axis_tdata[15];
                    mag    = {16'd0, n1_neg ? 16'(-s_axis_tdata[15:0]) : s_axis_tdata[15:0]};
                    n1_exp = 10'sd143;
                end
                FMT_S24: begin
                    n1_neg = s_axis_tdata[23];
                    mag    = {8'd0, n1_neg ? 24'(-s_axis_tdata[23:0]) : s_axis_tdata[23:0]};
                    n1_exp = 10'sd135;
                end
                default: begin
                    n1_neg = s_axis_tdata[31];
                    mag    = n1_neg ? (-s_axis_tdata) : s_axis_tdata;
                    n1_exp = 10'sd127;
                end
            endcase
            n1_val = {mag, 24'd0};
        end else begin
            n1_neg   = s_axis_tdata[31];
            n1_val   = PW'(fm) * PW'(scale);
            n1_exp   = (fe == 8'd0) ? -10'sd117 : ($signed({2'b00, fe}) - 10'sd118);
            if (fe == 8'hFF && ff != 23'd0) begin
                n1_neg   = 1'b0;
                n1_force = 1'b1;
            end else if (fe >= 8'd127) begin
                n1_force = 1'b1;
            end
        end
    end

    // Stage 2 and 3: normalize, then round to 24 significant bits.
    always_comb begin
        lz  = lzc56(r1_val);
        rnd = r2_norm[31] && ((|r2_norm[30:0]) || r2_norm[32]);
    end

    // Stage 4: float packing, or integer rounding and saturation.
    always_comb begin
        unique case (r3_fmt)
            FMT_S16: begin maxpos = MAX_S16; mask = MASK_S16; end
            FMT_S24: begin maxpos = MAX_S24; mask = MASK_S24; end
            default: begin maxpos = MAX_S32; mask = MASK_S32; end
        endcase
        bexp  = r3_exp[7:0] + {7'd0, r3_p[24]};
        rsh   = (r3_exp < -10'sd25) ? 5'd25 : 5'(-r3_exp);
        wide  = {r3_p, 25'd0} >> rsh;
        q     = wide[49:25];
        r_int = '0;
        if (r3_force) begin
            unique case (r3_fmt)
                FMT_S16: r_int = {2'b00, SCALE_S16};
                FMT_S24: r_int = {2'b00, SCALE_S24};
                default: r_int = {2'b00, SCALE_S32};
            endcase
        end else if (r3_exp >= 10'sd0) begin
            r_int = {9'd0, r3_p} << r3_exp[3:0];
        end else if (r3_exp >= -10'sd25) begin
            r_int = {9'd0, q + {24'd0, wide[24] && ((|wide[23:0]) || q[0])}};
        end
        if (r3_kind == KIND_PCM2FLT) begin
            if (r3_p == 25'd0) begin
                n4_data = 32'd0;
            end else begin
                n4_data = {r3_neg, bexp, r3_p[24] ? 23'd0 : r3_p[22:0]};
            end
        end else if (r3_neg) begin
            n4_data = (-r_int[31:0]) & mask;
        end else begin
            n4_data = (r_int > {2'b00, maxpos}) ? maxpos : r_int[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else if (adv) begin
            r1_v <= s_axis_tvalid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
        end
        if (adv) begin
            r1_kind  <= s_axis_tuser;
            r1_last  <= s_axis_tlast;
            r1_fmt   <= n1_fmt;
            r1_neg   <= n1_neg;
            r1_force <= n1_force;
            r1_val   <= n1_val;
            r1_exp   <= n1_exp;

            r2_kind  <= r1_kind;
            r2_last  <= r1_last;
            r2_fmt   <= r1_fmt;
            r2_neg   <= r1_neg;
            r2_force <= r1_force;
            r2_norm  <= r1_val << lz;
            r2_exp   <= r1_exp - $signed({4'd0, lz});

            r3_kind  <= r2_kind;
            r3_last  <= r2_last;
            r3_fmt   <= r2_fmt;
            r3_neg   <= r2_neg;
            r3_force <= r2_force;
            r3_p     <= {1'b0, r2_norm[55:32]} + {24'd0, rnd};
            r3_exp   <= r2_exp;

            r4_kind  <= r3_kind;
            r4_last  <= r3_last;
            r4_fmt   <= r3_fmt;
            r4_data  <= n4_data;
        end
    end

    `PFSC_ASSERT(a_stall_hold, i_clk, i_rst_n,
        r4_v && !m_axis_tready |=> r4_v && $stable(r4_data), "stalled beat changed")
    `PFSC_ASSERT(a_advance, i_clk, i_rst_n, adv && r3_v |=> r4_v, "beat lost between stages")
    `PFSC_ASSERT(a_s16_width, i_clk, i_rst_n,
        r4_v && r4_kind && r4_fmt == FMT_S16 |-> r4_data[31:16] == 16'd0,
        "16-bit result exceeds its width")
    `PFSC_ASSERT(a_flt_range, i_clk, i_rst_n,
        r4_v && !r4_kind |-> r4_data[30:23] <= 8'd127, "float result above full scale")
    `PFSC_ASSERT_ALWAYS(a_fmt_reset, i_clk,
        !r_fmt_valid |-> r_fmt == FMT_S16 || !$past(i_rst_n), "format not at reset value")

endmodule
